@@ design/timestamp_lru_tile_table_unit_defines.svh @@
// Assertion macros for the timestamp LRU tile table unit.
// Depends on clk_i and rst_ni being present in the module that uses them.
`ifndef TIMESTAMP_LRU_TILE_TABLE_UNIT_DEFINES_SVH
`define TIMESTAMP_LRU_TILE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TLT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tile table assertion failed");

// Next-cycle implication, disabled during reset.
`define TLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tile table assertion failed");

`endif

@@ design/tlt_pkg.sv @@
// Package for the timestamp LRU tile table unit.
// Holds transfer payload types, cell types and shared constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlt_pkg;

  localparam int unsigned Slots   = 16;
  localparam int unsigned TagW    = 16;
  localparam int unsigned StampW  = 31;
  localparam int unsigned SlotW   = 4;

  localparam logic KindLoad    = 1'b0;
  localparam logic KindRefresh = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic signed [TagW-1:0]  tag_x;
    logic signed [TagW-1:0]  tag_y;
    logic [StampW-1:0]       now_ms;
  } in_item_t;

  typedef struct packed {
    logic [SlotW-1:0]        slot;
    logic                    hit;
    logic                    evicted;
    logic signed [TagW-1:0]  evicted_x;
    logic signed [TagW-1:0]  evicted_y;
  } out_item_t;

  typedef struct packed {
    logic signed [TagW-1:0]  x;
    logic signed [TagW-1:0]  y;
    logic [StampW-1:0]       stamp;
  } entry_t;

  typedef struct packed {
    logic                    kind;
    logic signed [TagW-1:0]  tag_x;
    logic signed [TagW-1:0]  tag_y;
    logic [StampW-1:0]       now_ms;
    logic                    hit;
    logic [StampW-1:0]       best_stamp;
    logic signed [TagW-1:0]  best_x;
    logic signed [TagW-1:0]  best_y;
  } probe_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StWalk = 3'b010,
    StDone = 3'b100
  } state_e;

endpackage

`default_nettype wire

@@ design/tlt_cell.sv @@
// One table cell: holds a single entry and one stage of the search probe.
// Depends on tlt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlt_cell #(
  parameter int unsigned Slots = tlt_pkg::Slots,
  parameter int unsigned Idx   = 0
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  filled_i,
  input  wire                                  wr_sel_i,
  input  tlt_pkg::entry_t                      wr_data_i,
  input  wire                                  prb_valid_i,
  input  tlt_pkg::probe_t                      prb_i,
  input  wire [((Slots > 1) ? $clog2(Slots) : 1)-1:0] prb_hit_idx_i,
  input  wire [((Slots > 1) ? $clog2(Slots) : 1)-1:0] prb_best_idx_i,
  output logic                                 prb_valid_o,
  output tlt_pkg::probe_t                      prb_o,
  output logic [((Slots > 1) ? $clog2(Slots) : 1)-1:0] prb_hit_idx_o,
  output logic [((Slots > 1) ? $clog2(Slots) : 1)-1:0] prb_best_idx_o
);

  localparam int unsigned IdxW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);
  localparam bit First = (Idx == 0);

  tlt_pkg::entry_t ent_q, ent_d;
  tlt_pkg::probe_t prb_q, prb_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic            vld_q;
  logic            match;
  logic            older;

  always_comb begin
    ent_d = ent_q;
    if (wr_sel_i) begin
      ent_d = wr_data_i;
    end else if (prb_valid_i && (prb_i.kind == tlt_pkg::KindRefresh) && filled_i) begin
      ent_d.stamp = prb_i.now_ms;
    end
  end

  assign match = filled_i && (ent_q.x == prb_i.tag_x) && (ent_q.y == prb_i.tag_y);
  assign older = First || (ent_q.stamp < prb_i.best_stamp);

  always_comb begin
    prb_d      = prb_i;
    hit_idx_d  = prb_hit_idx_i;
    best_idx_d = prb_best_idx_i;
    if (!prb_i.hit && match) begin
      prb_d.hit = 1'b1;
      hit_idx_d = MyIdx;
    end
    if (older) begin
      prb_d.best_stamp = ent_q.stamp;
      prb_d.best_x     = ent_q.x;
      prb_d.best_y     = ent_q.y;
      best_idx_d       = MyIdx;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q      <= ent_d;
    prb_q      <= prb_d;
    hit_idx_q  <= hit_idx_d;
    best_idx_q <= best_idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= prb_valid_i;
    end
  end

  assign prb_valid_o    = vld_q;
  assign prb_o          = prb_q;
  assign prb_hit_idx_o  = hit_idx_q;
  assign prb_best_idx_o = best_idx_q;

endmodule

`default_nettype wire

@@ design/timestamp_lru_tile_table_unit.sv @@
// Top level of the timestamp LRU tile table: chain of tlt_cell, control and result register.
// Depends on tlt_pkg, tlt_cell and timestamp_lru_tile_table_unit_defines.svh.
//
// Usage:
//   Input channel in_valid_i/in_ready_o/in_data_i carries one item: kind selects a
//   tag load (lookup, fill or LRU replace) or a refresh of all filled stamps.
//   Output channel out_valid_o/out_ready_i/out_data_o returns one result per item.
//   An accepted item enters cell 0 at the transfer edge and moves one cell per
//   cycle through the cell chain; the probe from the last cell is then captured,
//   after which the table is written and the result register loaded. One item is
//   in flight at a time; the next transfer is taken once the block is back in idle.
//   A stalled receiver holds the result in the output register; a finished walk
//   then waits until that register is free before updating the table.
//   Reset empties the table (fill count zero) and drops any item in flight;
//   entry contents are not cleared, there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "timestamp_lru_tile_table_unit_defines.svh"

module timestamp_lru_tile_table_unit #(
  parameter int unsigned Slots = tlt_pkg::Slots
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  tlt_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output tlt_pkg::out_item_t  out_data_o
);

  localparam int unsigned IdxW  = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CntW  = $clog2(Slots + 1);
  localparam int unsigned SlotW = tlt_pkg::SlotW;

  tlt_pkg::state_e    state_q, state_d;
  logic [CntW-1:0]    fill_q, fill_d;
  logic               out_valid_q, out_valid_d;
  tlt_pkg::out_item_t out_data_q, res;

  tlt_pkg::probe_t    done_prb_q;
  logic [IdxW-1:0]    done_hit_idx_q;
  logic [IdxW-1:0]    done_best_idx_q;

  logic               chain_vld      [Slots+1];
  tlt_pkg::probe_t    chain_prb      [Slots+1];
  logic [IdxW-1:0]    chain_hit_idx  [Slots+1];
  logic [IdxW-1:0]    chain_best_idx [Slots+1];
  tlt_pkg::probe_t    launch_prb;

  logic [Slots-1:0]   filled;
  logic [Slots-1:0]   wr_sel;
  logic               wr_en;
  logic [IdxW-1:0]    wr_idx;
  tlt_pkg::entry_t    wr_data;

  logic               in_xfer;
  logic               tail_done;
  logic               finish;
  logic               full;

  assign in_ready_o = (state_q == tlt_pkg::StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign tail_done  = (state_q == tlt_pkg::StWalk) && chain_vld[Slots];
  assign finish     = (state_q == tlt_pkg::StDone) && (!out_valid_q || out_ready_i);
  assign full       = (fill_q == CntW'(Slots));

  always_comb begin
    launch_prb        = '0;
    launch_prb.kind   = in_data_i.kind;
    launch_prb.tag_x  = in_data_i.tag_x;
    launch_prb.tag_y  = in_data_i.tag_y;
    launch_prb.now_ms = in_data_i.now_ms;
  end

  assign chain_vld[0]      = in_xfer;
  assign chain_prb[0]      = launch_prb;
  assign chain_hit_idx[0]  = '0;
  assign chain_best_idx[0] = '0;

  for (genvar i = 0; i < Slots; i++) begin : g_cell
    assign filled[i] = (CntW'(i) < fill_q);
    assign wr_sel[i] = wr_en && (wr_idx == IdxW'(i));

    tlt_cell #(
      .Slots (Slots),
      .Idx   (i)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .filled_i       (filled[i]),
      .wr_sel_i       (wr_sel[i]),
      .wr_data_i      (wr_data),
      .prb_valid_i    (chain_vld[i]),
      .prb_i          (chain_prb[i]),
      .prb_hit_idx_i  (chain_hit_idx[i]),
      .prb_best_idx_i (chain_best_idx[i]),
      .prb_valid_o    (chain_vld[i+1]),
      .prb_o          (chain_prb[i+1]),
      .prb_hit_idx_o  (chain_hit_idx[i+1]),
      .prb_best_idx_o (chain_best_idx[i+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (tail_done) begin
      done_prb_q      <= chain_prb[Slots];
      done_hit_idx_q  <= chain_hit_idx[Slots];
      done_best_idx_q <= chain_best_idx[Slots];
    end
    if (finish) begin
      out_data_q <= res;
    end
  end

  always_comb begin
    res           = '0;
    wr_en         = 1'b0;
    wr_idx        = done_best_idx_q;
    fill_d        = fill_q;
    wr_data.x     = done_prb_q.tag_x;
    wr_data.y     = done_prb_q.tag_y;
    wr_data.stamp = done_prb_q.now_ms;
    if (done_prb_q.kind == tlt_pkg::KindRefresh) begin
      res = '0;
    end else if (done_prb_q.hit) begin
      res.hit  = 1'b1;
      res.slot = SlotW'(done_hit_idx_q);
    end else if (full) begin
      res.slot      = SlotW'(done_best_idx_q);
      res.evicted   = 1'b1;
      res.evicted_x = done_prb_q.best_x;
      res.evicted_y = done_prb_q.best_y;
      wr_en         = finish;
    end else begin
      res.slot = SlotW'(fill_q);
      wr_idx   = IdxW'(fill_q);
      wr_en    = finish;
      if (finish) begin
        fill_d = fill_q + CntW'(1);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tlt_pkg::StIdle: begin
        if (in_xfer) state_d = tlt_pkg::StWalk;
      end
      tlt_pkg::StWalk: begin
        if (tail_done) state_d = tlt_pkg::StDone;
      end
      tlt_pkg::StDone: begin
        if (finish) state_d = tlt_pkg::StIdle;
      end
      default: state_d = tlt_pkg::StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlt_pkg::StIdle;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `TLT_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= CntW'(Slots))
  `TLT_ASSERT_NEXT(a_xfer_walk, in_xfer, state_q == tlt_pkg::StWalk)
  `TLT_ASSERT_IMPL(a_evict_full, out_valid_q && out_data_q.evicted, full)
  `TLT_ASSERT_IMPL(a_tail_in_walk, chain_vld[Slots], state_q == tlt_pkg::StWalk)

endmodule

`default_nettype wire
